// ===== rtl/opp_pkg.sv =====
`timescale 1ns / 1ps
package opp_pkg;

	typedef enum logic [2:0] {
		REG_QUAT_WX = 3'd0,
		REG_QUAT_YZ = 3'd1,
		REG_BOX_LO  = 3'd2,
		REG_BOX_HI  = 3'd3,
		REG_ZOOM    = 3'd4,
		REG_CX      = 3'd5,
		REG_CY      = 3'd6,
		REG_SCALE   = 3'd7
	} opp_reg_t;

	localparam int ROT_W     = 24;
	localparam int ROT_FRAC  = 22;
	localparam int NORM_FRAC = 16;
	localparam int NSTAGE    = 13;
	localparam int PIX_W     = 17;
	localparam int ZOOM_W    = 24;
	localparam int P_W       = PIX_W + ZOOM_W;
	localparam int SCR_W     = 22;
	localparam int DEPTH_W   = 19;
	localparam int CFG_W     = 64;

	typedef logic [8:0][ROT_W-1:0] opp_mat_t;
	typedef logic [NSTAGE:1] opp_en_t;

endpackage

// ===== rtl/opp_setup.sv =====
`timescale 1ns / 1ps
module opp_setup #(
	parameter int COORD_BITS = 21
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [63:0]                                 quat_wx,
	input  logic [63:0]                                 quat_yz,
	input  logic [3*COORD_BITS-1:0]                     box_lo,
	input  logic [3*COORD_BITS-1:0]                     box_hi,
	output logic                                        busy,
	output opp_pkg::opp_mat_t                           rot,
	output logic [((COORD_BITS > 9) ? COORD_BITS : 9):0] den,
	output logic [COORD_BITS+17:0]                      recip
);
	import opp_pkg::*;

	localparam int EW        = (COORD_BITS > 9) ? COORD_BITS : 9;
	localparam int DW        = EW + 1;
	localparam int S         = COORD_BITS + 2;
	localparam int RW        = COORD_BITS + 18;
	localparam int PROD_W    = 62;
	localparam int N_W       = 63;
	localparam int M_W       = 64;
	localparam int DIVD_W    = 86;
	localparam int REM_W     = 64;
	localparam int QW        = (RW > ROT_FRAC + 1) ? RW : ROT_FRAC + 1;
	localparam int DIV_STEPS = 86;
	localparam int N_PROD    = 10;
	localparam int REC_JOB   = 9;

	typedef enum logic [3:0] {
		ST_PROD = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_IDLE = 4'b1000
	} st_t;

	st_t state_q;
	logic [3:0] cnt_q;
	logic [3:0] job_q;
	logic [6:0] step_q;

	logic signed [31:0] raw [4];
	logic signed [31:0] rnd [4];
	logic signed [30:0] hq [4];
	logic signed [30:0] ma, mb;
	logic signed [PROD_W-1:0] prod_q [N_PROD];
	logic signed [M_W-1:0] e [N_PROD];
	logic signed [M_W-1:0] m_c [9];
	logic signed [M_W-1:0] m_q [9];
	logic signed [M_W-1:0] n_c;
	logic [N_W-1:0] n_q;
	logic signed [COORD_BITS:0] diff [3];
	logic signed [COORD_BITS:0] maxd;
	logic [EW-1:0] span;
	logic [DW-1:0] den_q;
	logic [RW-1:0] recip_q;
	opp_mat_t rot_q;

	logic [DIVD_W-1:0] divd_q;
	logic [N_W-1:0] dvs_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] rem_next;
	logic [QW-1:0] quo_q;
	logic sign_q;
	logic [M_W-1:0] m_mag;
	logic [ROT_FRAC:0] qv;
	logic [ROT_W-1:0] rot_val;

	always_comb begin
		raw[0] = quat_wx[63:32];
		raw[1] = quat_wx[31:0];
		raw[2] = quat_yz[63:32];
		raw[3] = quat_yz[31:0];
		for (int i = 0; i < 4; i++) begin
			rnd[i] = raw[i] + $signed({31'd0, raw[i][31]});
			hq[i]  = rnd[i][31:1];
		end
	end

	always_comb begin
		case (cnt_q)
			4'd0: begin ma = hq[0]; mb = hq[0]; end
			4'd1: begin ma = hq[1]; mb = hq[1]; end
			4'd2: begin ma = hq[2]; mb = hq[2]; end
			4'd3: begin ma = hq[3]; mb = hq[3]; end
			4'd4: begin ma = hq[1]; mb = hq[2]; end
			4'd5: begin ma = hq[1]; mb = hq[3]; end
			4'd6: begin ma = hq[2]; mb = hq[3]; end
			4'd7: begin ma = hq[0]; mb = hq[1]; end
			4'd8: begin ma = hq[0]; mb = hq[2]; end
			4'd9: begin ma = hq[0]; mb = hq[3]; end
			default: begin ma = hq[0]; mb = hq[0]; end
		endcase
	end

	// Products in order: ww, xx, yy, zz, xy, xz, yz, wx, wy, wz.
	always_comb begin
		for (int i = 0; i < N_PROD; i++) begin
			e[i] = M_W'(prod_q[i]);
		end
		n_c    = e[0] + e[1] + e[2] + e[3];
		m_c[0] = e[0] + e[1] - e[2] - e[3];
		m_c[1] = (e[4] - e[9]) <<< 1;
		m_c[2] = (e[5] + e[8]) <<< 1;
		m_c[3] = (e[4] + e[9]) <<< 1;
		m_c[4] = e[0] - e[1] + e[2] - e[3];
		m_c[5] = (e[6] - e[7]) <<< 1;
		m_c[6] = (e[5] - e[8]) <<< 1;
		m_c[7] = (e[6] + e[7]) <<< 1;
		m_c[8] = e[0] - e[1] - e[2] + e[3];
	end

	always_comb begin
		maxd = '0;
		for (int i = 0; i < 3; i++) begin
			diff[i] = $signed({box_hi[COORD_BITS*i+COORD_BITS-1], box_hi[COORD_BITS*i +: COORD_BITS]})
				- $signed({box_lo[COORD_BITS*i+COORD_BITS-1], box_lo[COORD_BITS*i +: COORD_BITS]});
			if (diff[i] > maxd) begin
				maxd = diff[i];
			end
		end
		span = (maxd == '0) ? EW'(256) : EW'(maxd[COORD_BITS-1:0]);
	end

	always_comb begin
		rem_next = {rem_q[REM_W-2:0], divd_q[DIVD_W-1]};
		m_mag    = m_q[job_q][M_W-1] ? M_W'(-m_q[job_q]) : M_W'(m_q[job_q]);
		qv       = quo_q[ROT_FRAC:0];
		rot_val  = sign_q ? ROT_W'(-ROT_W'(qv)) : ROT_W'(qv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PROD;
			cnt_q   <= '0;
			job_q   <= '0;
			step_q  <= '0;
		end else if (start) begin
			state_q <= ST_PROD;
			cnt_q   <= '0;
			job_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_PROD: begin
					if (cnt_q == 4'(N_PROD - 1)) begin
						state_q <= ST_SUM;
					end
					cnt_q <= cnt_q + 4'd1;
				end
				ST_SUM: begin
					state_q <= ST_DIV;
					job_q   <= '0;
					step_q  <= '0;
				end
				ST_DIV: begin
					if (step_q == 7'(DIV_STEPS + 1)) begin
						step_q <= '0;
						job_q  <= job_q + 4'd1;
						if (job_q == 4'(REC_JOB)) begin
							state_q <= ST_IDLE;
						end
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PROD) begin
			prod_q[cnt_q] <= ma * mb;
		end
		if (state_q == ST_SUM) begin
			n_q   <= n_c[N_W-1:0];
			m_q   <= m_c;
			den_q <= {span, 1'b0};
		end
		if (state_q == ST_DIV) begin
			if (step_q == '0) begin
				rem_q <= '0;
				quo_q <= '0;
				if (job_q == 4'(REC_JOB)) begin
					sign_q <= 1'b0;
					divd_q <= DIVD_W'(1) << (NORM_FRAC + S);
					dvs_q  <= N_W'(den_q);
				end else begin
					sign_q <= m_q[job_q][M_W-1];
					divd_q <= DIVD_W'(m_mag[N_W-1:0]) << ROT_FRAC;
					dvs_q  <= n_q;
				end
			end else if (step_q <= 7'(DIV_STEPS)) begin
				divd_q <= divd_q << 1;
				if (rem_next >= {1'b0, dvs_q}) begin
					rem_q <= rem_next - {1'b0, dvs_q};
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= rem_next;
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
			end else if (job_q == 4'(REC_JOB)) begin
				recip_q <= quo_q[RW-1:0];
			end else if (n_q == '0) begin
				rot_q[job_q] <= (job_q == 4'd0 || job_q == 4'd4 || job_q == 4'd8)
					? ROT_W'(1 << ROT_FRAC) : '0;
			end else begin
				rot_q[job_q] <= rot_val;
			end
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign rot   = rot_q;
	assign den   = den_q;
	assign recip = recip_q;

endmodule

// ===== rtl/opp_norm_lane.sv =====
`timescale 1ns / 1ps
module opp_norm_lane #(
	parameter int COORD_BITS = 21
) (
	input  logic                                        clk,
	input  opp_pkg::opp_en_t                            en,
	input  logic signed [COORD_BITS-1:0]                point,
	input  logic signed [COORD_BITS-1:0]                lo,
	input  logic signed [COORD_BITS-1:0]                hi,
	input  logic [((COORD_BITS > 9) ? COORD_BITS : 9):0] den,
	input  logic [COORD_BITS+17:0]                      recip,
	output logic signed [COORD_BITS+17:0]               v
);
	import opp_pkg::*;

	localparam int EW   = (COORD_BITS > 9) ? COORD_BITS : 9;
	localparam int DW   = EW + 1;
	localparam int RMW  = DW + 1;
	localparam int MAGW = COORD_BITS + 1;
	localparam int S    = COORD_BITS + 2;
	localparam int RW   = COORD_BITS + 18;
	localparam int QN   = COORD_BITS + 17;
	localparam int VW   = COORD_BITS + 18;
	localparam int PLW  = MAGW + 20;
	localparam int PHW  = MAGW + RW - 20;
	localparam int FW   = MAGW + RW + 1;

	logic signed [COORD_BITS+1:0] d2;
	logic [MAGW-1:0] mag_s1, mag_s2, mag_s3;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic [PLW-1:0] ppl_s2;
	logic [PHW-1:0] pph_s2;
	logic [FW-1:0] full;
	logic [QN-1:0] q0_s3, q0_s4;
	logic [RMW-1:0] low_s4, nl_s4, rem;
	logic [MAGW+NORM_FRAC-1:0] num;
	logic [QN-1:0] q;
	logic signed [VW-1:0] v_s5;

	always_comb begin
		d2 = $signed({point[COORD_BITS-1], point, 1'b0})
			- $signed({{2{lo[COORD_BITS-1]}}, lo})
			- $signed({{2{hi[COORD_BITS-1]}}, hi});
		full = (FW'(pph_s2) << 20) + FW'(ppl_s2);
		num  = {mag_s3, {NORM_FRAC{1'b0}}};
		rem  = nl_s4 - low_s4;
		q    = q0_s4 + QN'(rem >= RMW'(den));
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			neg_s1 <= d2[COORD_BITS+1];
			mag_s1 <= d2[COORD_BITS+1] ? MAGW'(-d2) : MAGW'(d2);
		end
		if (en[2]) begin
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			ppl_s2 <= PLW'(mag_s1 * recip[19:0]);
			pph_s2 <= PHW'(mag_s1 * recip[RW-1:20]);
		end
		if (en[3]) begin
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			q0_s3  <= full[S +: QN];
		end
		if (en[4]) begin
			neg_s4 <= neg_s3;
			q0_s4  <= q0_s3;
			low_s4 <= RMW'(q0_s3[RMW-1:0] * den);
			nl_s4  <= num[RMW-1:0];
		end
		if (en[5]) begin
			v_s5 <= neg_s4 ? VW'(-VW'(q)) : VW'(q);
		end
	end

	assign v = v_s5;

endmodule

// ===== rtl/opp_rot_lane.sv =====
`timescale 1ns / 1ps
module opp_rot_lane #(
	parameter int COORD_BITS = 21
) (
	input  logic                                  clk,
	input  opp_pkg::opp_en_t                      en,
	input  logic [2:0][COORD_BITS+17:0]           v_in,
	input  logic [2:0][opp_pkg::ROT_W-1:0]        row,
	output logic signed [COORD_BITS+19:0]         view
);
	import opp_pkg::*;

	localparam int VW     = COORD_BITS + 18;
	localparam int VIEW_W = COORD_BITS + 20;
	localparam int PLW    = ROT_W + 21;
	localparam int PHW    = ROT_W + VW - 20;
	localparam int SLW    = PLW + 2;
	localparam int SHW    = PHW + 2;
	localparam int SW     = ROT_W + VW + 3;

	logic signed [PLW-1:0] pl_s6 [3];
	logic signed [PHW-1:0] ph_s6 [3];
	logic signed [SLW-1:0] sl_s7;
	logic signed [SHW-1:0] sh_s7;
	logic signed [SW-1:0] s_s8;
	logic signed [SW-1:0] s_b;
	logic signed [VIEW_W-1:0] view_s9;

	always_comb begin
		s_b = s_s8 + (s_s8[SW-1] ? SW'((1 << ROT_FRAC) - 1) : SW'(0));
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int j = 0; j < 3; j++) begin
				pl_s6[j] <= $signed(row[j]) * $signed({1'b0, v_in[j][19:0]});
				ph_s6[j] <= $signed(row[j]) * $signed(v_in[j][VW-1:20]);
			end
		end
		if (en[7]) begin
			sl_s7 <= SLW'(pl_s6[0]) + SLW'(pl_s6[1]) + SLW'(pl_s6[2]);
			sh_s7 <= SHW'(ph_s6[0]) + SHW'(ph_s6[1]) + SHW'(ph_s6[2]);
		end
		if (en[8]) begin
			s_s8 <= (SW'(sh_s7) <<< 20) + SW'(sl_s7);
		end
		if (en[9]) begin
			view_s9 <= $signed(s_b[ROT_FRAC +: VIEW_W]);
		end
	end

	assign view = view_s9;

endmodule

// ===== rtl/opp_screen.sv =====
`timescale 1ns / 1ps
module opp_screen #(
	parameter int COORD_BITS = 21
) (
	input  logic                                  clk,
	input  opp_pkg::opp_en_t                      en,
	input  logic signed [COORD_BITS+19:0]         view_x,
	input  logic signed [COORD_BITS+19:0]         view_y,
	input  logic signed [COORD_BITS+19:0]         view_z,
	input  logic [opp_pkg::P_W-1:0]               p,
	input  logic [opp_pkg::PIX_W-1:0]             cx,
	input  logic [opp_pkg::PIX_W-1:0]             cy,
	output logic signed [opp_pkg::SCR_W-1:0]      screen_x,
	output logic signed [opp_pkg::SCR_W-1:0]      screen_y,
	output logic signed [opp_pkg::DEPTH_W-1:0]    view_depth
);
	import opp_pkg::*;

	localparam int VIEW_W = COORD_BITS + 20;
	localparam int MW     = VIEW_W;
	localparam int MHW    = MW - 20;
	localparam int PLW    = P_W - 20;
	localparam int PHW    = 20;
	localparam int FW     = P_W + MW + 1;
	localparam int TW     = P_W + MW - 32;
	localparam int SXW    = TW + 2;
	localparam logic signed [SXW-1:0] SX_MAX = SXW'((1 << (SCR_W - 1)) - 1);
	localparam logic signed [SXW-1:0] SX_MIN = SXW'(-(1 << (SCR_W - 1)));
	localparam logic signed [VIEW_W-1:0] DP_MAX = VIEW_W'((1 << (DEPTH_W - 1)) - 1);
	localparam logic signed [VIEW_W-1:0] DP_MIN = VIEW_W'(-(1 << (DEPTH_W - 1)));

	logic signed [VIEW_W-1:0] vw [2];
	logic neg_s10 [2], neg_s11 [2], neg_s12 [2];
	logic [MW-1:0] mag_s10 [2];
	logic [PLW+20-1:0] ll_s11 [2];
	logic [PLW+MHW-1:0] lh_s11 [2];
	logic [PHW+20-1:0] hl_s11 [2];
	logic [PHW+MHW-1:0] hh_s11 [2];
	logic [FW-1:0] sum [2];
	logic [TW-1:0] t_s12 [2];
	logic signed [SXW-1:0] off [2];
	logic signed [SXW-1:0] sc [2];
	logic signed [DEPTH_W-1:0] dp_s10, dp_s11, dp_s12, dp_s13;
	logic signed [SCR_W-1:0] sx_s13, sy_s13;

	always_comb begin
		vw[0] = view_x;
		vw[1] = view_y;
		for (int a = 0; a < 2; a++) begin
			sum[a] = FW'(ll_s11[a]) + (FW'(lh_s11[a]) << 20)
				+ (FW'(hl_s11[a]) << PLW) + (FW'(hh_s11[a]) << (PLW + 20));
			off[a] = neg_s12[a] ? SXW'(-SXW'(t_s12[a])) : SXW'(t_s12[a]);
		end
		sc[0] = SXW'(cx) + off[0];
		sc[1] = SXW'(cy) - off[1];
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			for (int a = 0; a < 2; a++) begin
				neg_s10[a] <= vw[a][VIEW_W-1];
				mag_s10[a] <= vw[a][VIEW_W-1] ? MW'(-vw[a]) : MW'(vw[a]);
			end
			if (view_z > DP_MAX) begin
				dp_s10 <= DP_MAX[DEPTH_W-1:0];
			end else if (view_z < DP_MIN) begin
				dp_s10 <= DP_MIN[DEPTH_W-1:0];
			end else begin
				dp_s10 <= view_z[DEPTH_W-1:0];
			end
		end
		if (en[11]) begin
			for (int a = 0; a < 2; a++) begin
				neg_s11[a] <= neg_s10[a];
				ll_s11[a]  <= p[PLW-1:0] * mag_s10[a][19:0];
				lh_s11[a]  <= p[PLW-1:0] * mag_s10[a][MW-1:20];
				hl_s11[a]  <= p[P_W-1:PLW] * mag_s10[a][19:0];
				hh_s11[a]  <= p[P_W-1:PLW] * mag_s10[a][MW-1:20];
			end
			dp_s11 <= dp_s10;
		end
		if (en[12]) begin
			for (int a = 0; a < 2; a++) begin
				neg_s12[a] <= neg_s11[a];
				t_s12[a]   <= sum[a][32 +: TW];
			end
			dp_s12 <= dp_s11;
		end
		if (en[13]) begin
			if (sc[0] > SX_MAX) begin
				sx_s13 <= SX_MAX[SCR_W-1:0];
			end else if (sc[0] < SX_MIN) begin
				sx_s13 <= SX_MIN[SCR_W-1:0];
			end else begin
				sx_s13 <= sc[0][SCR_W-1:0];
			end
			if (sc[1] > SX_MAX) begin
				sy_s13 <= SX_MAX[SCR_W-1:0];
			end else if (sc[1] < SX_MIN) begin
				sy_s13 <= SX_MIN[SCR_W-1:0];
			end else begin
				sy_s13 <= sc[1][SCR_W-1:0];
			end
			dp_s13 <= dp_s12;
		end
	end

	assign screen_x   = sx_s13;
	assign screen_y   = sy_s13;
	assign view_depth = dp_s13;

endmodule

// ===== rtl/ortho_point_projector_top.sv =====
`timescale 1ns / 1ps
// Projects one world point per clock onto the screen while in_stall is low: three normalising
// lanes, three rotation lanes and a screen scaling block, with each stage advancing whenever the
// one after it can take its contents. After reset and after every configuration write the block
// rebuilds its rotation matrix and span reciprocal with one shared shift-subtract divider, ten
// divisions after the products and sums, and holds in_stall high meanwhile.
module ortho_point_projector_top #(
	parameter int COORD_BITS = 21
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  opp_pkg::opp_reg_t                    cfg_index,
	input  logic [opp_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_BITS-1:0]         point_x,
	input  logic signed [COORD_BITS-1:0]         point_y,
	input  logic signed [COORD_BITS-1:0]         point_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [opp_pkg::SCR_W-1:0]     screen_x,
	output logic signed [opp_pkg::SCR_W-1:0]     screen_y,
	output logic signed [opp_pkg::DEPTH_W-1:0]   view_depth
);
	import opp_pkg::*;

	localparam int EW     = (COORD_BITS > 9) ? COORD_BITS : 9;
	localparam int VW     = COORD_BITS + 18;
	localparam int VIEW_W = COORD_BITS + 20;

	logic [63:0] quat_wx_q, quat_yz_q;
	logic [3*COORD_BITS-1:0] box_lo_q, box_hi_q;
	logic [ZOOM_W-1:0] zoom_q;
	logic [PIX_W-1:0] cx_q, cy_q, scale_q;
	logic [P_W-1:0] p_q;
	logic cfg_we;
	logic busy;
	opp_mat_t rot;
	logic [EW:0] den;
	logic [COORD_BITS+17:0] recip;
	opp_en_t en;
	opp_en_t v_q;
	logic accept;
	logic signed [COORD_BITS-1:0] pts [3];
	logic [2:0][VW-1:0] v;
	logic signed [VIEW_W-1:0] view [3];

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_wx_q <= 64'h2000_0000_0000_0000;
			quat_yz_q <= '0;
			box_lo_q  <= '0;
			box_hi_q  <= '0;
			zoom_q    <= ZOOM_W'(65536);
			cx_q      <= '0;
			cy_q      <= '0;
			scale_q   <= PIX_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUAT_WX: quat_wx_q <= cfg_data;
				REG_QUAT_YZ: quat_yz_q <= cfg_data;
				REG_BOX_LO:  box_lo_q  <= cfg_data[3*COORD_BITS-1:0];
				REG_BOX_HI:  box_hi_q  <= cfg_data[3*COORD_BITS-1:0];
				REG_ZOOM:    zoom_q    <= cfg_data[ZOOM_W-1:0];
				REG_CX:      cx_q      <= cfg_data[PIX_W-1:0];
				REG_CY:      cy_q      <= cfg_data[PIX_W-1:0];
				REG_SCALE:   scale_q   <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= scale_q * zoom_q;
	end

	always_comb begin
		en[NSTAGE] = ~v_q[NSTAGE] | ~out_stall;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en[k] = ~v_q[k] | en[k+1];
		end
	end

	assign in_stall  = busy | ~en[1];
	assign accept    = in_valid & ~in_stall;
	assign out_valid = v_q[NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= accept;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	opp_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_we),
		.quat_wx (quat_wx_q),
		.quat_yz (quat_yz_q),
		.box_lo  (box_lo_q),
		.box_hi  (box_hi_q),
		.busy    (busy),
		.rot     (rot),
		.den     (den),
		.recip   (recip)
	);

	assign pts[0] = point_x;
	assign pts[1] = point_y;
	assign pts[2] = point_z;

	for (genvar a = 0; a < 3; a++) begin : g_norm
		logic signed [VW-1:0] v_lane;
		opp_norm_lane #(.COORD_BITS(COORD_BITS)) u_norm (
			.clk   (clk),
			.en    (en),
			.point (pts[a]),
			.lo    ($signed(box_lo_q[COORD_BITS*a +: COORD_BITS])),
			.hi    ($signed(box_hi_q[COORD_BITS*a +: COORD_BITS])),
			.den   (den),
			.recip (recip),
			.v     (v_lane)
		);
		assign v[a] = v_lane;
	end

	for (genvar i = 0; i < 3; i++) begin : g_rot
		opp_rot_lane #(.COORD_BITS(COORD_BITS)) u_rot (
			.clk  (clk),
			.en   (en),
			.v_in (v),
			.row  (rot[3*i+2:3*i]),
			.view (view[i])
		);
	end

	opp_screen #(.COORD_BITS(COORD_BITS)) u_screen (
		.clk        (clk),
		.en         (en),
		.view_x     (view[0]),
		.view_y     (view[1]),
		.view_z     (view[2]),
		.p          (p_q),
		.cx         (cx_q),
		.cy         (cy_q),
		.screen_x   (screen_x),
		.screen_y   (screen_y),
		.view_depth (view_depth)
	);

	a_cfg_starts_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy)
		else $error("configuration write did not start the setup pass");

	a_no_items_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> v_q == '0)
		else $error("transaction in flight during the setup pass");

	a_out_from_last_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[NSTAGE-1] && !(out_valid && out_stall) |=> !out_valid)
		else $error("result appeared without a transaction in the last stage");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import opp_pkg::*;

	typedef struct {
		logic signed [SCR_W-1:0]   sx;
		logic signed [SCR_W-1:0]   sy;
		logic signed [DEPTH_W-1:0] depth;
	} projection_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	opp_reg_t cfg_index = REG_QUAT_WX;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [20:0] point_x = '0, point_y = '0, point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SCR_W-1:0] screen_x, screen_y;
	logic signed [DEPTH_W-1:0] view_depth;

	logic [63:0] cam_wx, cam_yz, box_lo, box_hi;
	logic [23:0] zoom;
	logic [16:0] centre_x, centre_y, px_scale;

	projection_t pending_projections[$];
	int failures = 0;
	int points_sent = 0;
	int results_seen = 0;
	int phases = 0;
	int burst_left = 4;
	int stall_mode = 0;
	int stall_count = 0;

	ortho_point_projector_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.screen_x(screen_x), .screen_y(screen_y), .view_depth(view_depth)
	);

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint clamp_to(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint rot_entry(longint num, longint unsigned den);
		longint unsigned mag, q, r;
		mag = num < 0 ? longint'(-num) : num;
		q = mag / den;
		r = mag % den;
		for (int i = 0; i < ROT_FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint pixel_offset(longint unsigned p, longint view);
		longint unsigned mag, t;
		mag = view < 0 ? longint'(-view) : view;
		t = (p * (mag >> 20) + ((p * (mag & 64'hFFFFF)) >> 20)) >> 12;
		return view < 0 ? -longint'(t) : longint'(t);
	endfunction

	function automatic projection_t project_point(longint pt[3]);
		longint lo[3], hi[3], v[3], view[3], m[9], rot[9];
		longint span, w, x, y, z, s;
		longint unsigned n, p;
		projection_t res;
		span = 0;
		for (int i = 0; i < 3; i++) begin
			lo[i] = longint'($signed(box_lo[i*21 +: 21]));
			hi[i] = longint'($signed(box_hi[i*21 +: 21]));
			if (hi[i] - lo[i] > span)
				span = hi[i] - lo[i];
		end
		if (span <= 0)
			span = 256;
		for (int i = 0; i < 3; i++)
			v[i] = ((2 * pt[i] - lo[i] - hi[i]) * 65536) / (2 * span);
		w = longint'($signed(cam_wx[63:32])) / 2;
		x = longint'($signed(cam_wx[31:0])) / 2;
		y = longint'($signed(cam_yz[63:32])) / 2;
		z = longint'($signed(cam_yz[31:0])) / 2;
		n = w * w + x * x + y * y + z * z;
		m[0] = w * w + x * x - y * y - z * z;
		m[1] = 2 * (x * y - w * z);
		m[2] = 2 * (x * z + w * y);
		m[3] = 2 * (x * y + w * z);
		m[4] = w * w - x * x + y * y - z * z;
		m[5] = 2 * (y * z - w * x);
		m[6] = 2 * (x * z - w * y);
		m[7] = 2 * (y * z + w * x);
		m[8] = w * w - x * x - y * y + z * z;
		for (int i = 0; i < 9; i++)
			rot[i] = n == 0 ? ((i % 4 == 0) ? (longint'(1) <<< ROT_FRAC) : 0)
				: rot_entry(m[i], n);
		for (int i = 0; i < 3; i++) begin
			s = rot[3*i] * v[0] + rot[3*i+1] * v[1] + rot[3*i+2] * v[2];
			view[i] = s / (longint'(1) <<< ROT_FRAC);
		end
		p = longint'(px_scale) * longint'(zoom);
		res.sx = SCR_W'(clamp_to(longint'(centre_x) + pixel_offset(p, view[0]), SCR_W));
		res.sy = SCR_W'(clamp_to(longint'(centre_y) - pixel_offset(p, view[1]), SCR_W));
		res.depth = DEPTH_W'(clamp_to(view[2], DEPTH_W));
		return res;
	endfunction

	task automatic write_reg(opp_reg_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_QUAT_WX: cam_wx = val;
			REG_QUAT_YZ: cam_yz = val;
			REG_BOX_LO:  box_lo = {1'b0, val[62:0]};
			REG_BOX_HI:  box_hi = {1'b0, val[62:0]};
			REG_ZOOM:    zoom = val[23:0];
			REG_CX:      centre_x = val[16:0];
			REG_CY:      centre_y = val[16:0];
			REG_SCALE:   px_scale = val[16:0];
		endcase
		@(posedge clk);
	endtask

	task automatic send_point(logic signed [20:0] x, logic signed [20:0] y, logic signed [20:0] z);
		longint pt[3];
		int gap;
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		do @(posedge clk); while (in_stall);
		pt = '{longint'(x), longint'(y), longint'(z)};
		pending_projections.push_back(project_point(pt));
		points_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_projections.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		phases++;
	endtask

	always @(posedge clk) begin
		stall_count <= stall_count + 1;
		if (stall_count % 97 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= (stall_count % 5 < 2);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	always @(posedge clk) begin
		projection_t exp_p;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_projections.size() == 0) begin
				$error("result with no point outstanding");
				failures++;
			end else begin
				exp_p = pending_projections.pop_front();
				if (screen_x !== exp_p.sx) begin
					$error("screen_x expected %0d actual %0d", exp_p.sx, screen_x);
					failures++;
				end
				if (screen_y !== exp_p.sy) begin
					$error("screen_y expected %0d actual %0d", exp_p.sy, screen_y);
					failures++;
				end
				if (view_depth !== exp_p.depth) begin
					$error("view_depth expected %0d actual %0d", exp_p.depth, view_depth);
					failures++;
				end
			end
		end
	end

	function automatic logic [62:0] pack_box(logic signed [20:0] x, logic signed [20:0] y,
		logic signed [20:0] z);
		return {z, y, x};
	endfunction

	task automatic test_reset_defaults;
		send_point(21'sd1048575, 21'sd1048575, 21'sd1048575);
		send_point(-21'sd1048576, -21'sd1048576, -21'sd1048576);
		send_point(21'sd0, 21'sd0, 21'sd0);
		send_point(21'sd256, -21'sd256, 21'sd128);
		drain();
	endtask

	task automatic test_rotation_and_box;
		write_reg(REG_QUAT_WX, {32'h2000_0000, 32'h2000_0000});
		write_reg(REG_QUAT_YZ, {32'hE000_0000, 32'h1000_0000});
		write_reg(REG_BOX_LO, pack_box(-21'sd2560, -21'sd512, 21'sd0));
		write_reg(REG_BOX_HI, pack_box(21'sd2560, 21'sd1024, 21'sd256));
		write_reg(REG_ZOOM, 24'h018000);
		write_reg(REG_CX, 17'd5120);
		write_reg(REG_CY, 17'd3840);
		write_reg(REG_SCALE, 17'd4000);
		send_point(21'sd0, 21'sd0, 21'sd0);
		send_point(21'sd2560, 21'sd1024, 21'sd256);
		send_point(-21'sd2560, -21'sd512, 21'sd0);
		send_point(21'sd1048575, -21'sd1048576, 21'sd77);
		drain();
	endtask

	task automatic test_zero_quat_inverted_box;
		write_reg(REG_QUAT_WX, 64'h0000_0001_FFFF_FFFF);
		write_reg(REG_QUAT_YZ, 64'h0000_0001_0000_0000);
		write_reg(REG_BOX_LO, pack_box(21'sd1000, 21'sd1000, 21'sd1000));
		write_reg(REG_BOX_HI, pack_box(-21'sd1000, -21'sd1000, -21'sd1000));
		send_point(21'sd300, -21'sd300, 21'sd1048575);
		send_point(-21'sd1048576, 21'sd1048575, -21'sd1048576);
		drain();
	endtask

	task automatic test_zero_scale_and_saturation;
		write_reg(REG_QUAT_WX, {32'h7FFF_FFFF, 32'h8000_0000});
		write_reg(REG_QUAT_YZ, {32'h8000_0000, 32'h7FFF_FFFF});
		write_reg(REG_BOX_LO, pack_box(21'sd0, 21'sd0, 21'sd0));
		write_reg(REG_BOX_HI, pack_box(21'sd1, 21'sd0, 21'sd0));
		write_reg(REG_ZOOM, 24'd0);
		write_reg(REG_CX, 17'h1FFFF);
		write_reg(REG_CY, 17'h1FFFF);
		send_point(21'sd1048575, -21'sd1048576, 21'sd1048575);
		send_point(-21'sd1048576, 21'sd1048575, -21'sd1048576);
		drain();
		write_reg(REG_ZOOM, 24'hFFFFFF);
		write_reg(REG_SCALE, 17'h1FFFF);
		send_point(21'sd1048575, -21'sd1048576, 21'sd1048575);
		send_point(-21'sd1048576, 21'sd1048575, -21'sd1048576);
		send_point(21'sd1, 21'sd0, -21'sd1);
		drain();
		write_reg(REG_SCALE, 17'd0);
		write_reg(REG_ZOOM, 24'h010000);
		send_point(21'sd12345, -21'sd54321, 21'sd999);
		drain();
	endtask

	task automatic random_config;
		logic signed [20:0] lo[3], hi[3];
		int kind;
		kind = $urandom_range(0, 4);
		if (kind == 0) begin
			write_reg(REG_QUAT_WX, {$urandom(), $urandom()});
			write_reg(REG_QUAT_YZ, {$urandom(), $urandom()});
		end else if (kind == 1) begin
			write_reg(REG_QUAT_WX, {32'($urandom_range(0, 1)), 32'($urandom_range(0, 1))});
			write_reg(REG_QUAT_YZ, 64'd0);
		end else begin
			write_reg(REG_QUAT_WX, {32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000),
				32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000)});
			write_reg(REG_QUAT_YZ, {32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000),
				32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000)});
		end
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_BOX_LO, {$urandom(), $urandom()});
			write_reg(REG_BOX_HI, {$urandom(), $urandom()});
		end else begin
			for (int i = 0; i < 3; i++) begin
				lo[i] = 21'($urandom());
				hi[i] = lo[i] + 21'($urandom_range(1, 1 << $urandom_range(1, 19)));
				if (hi[i] < lo[i])
					hi[i] = 21'sd1048575;
			end
			write_reg(REG_BOX_LO, pack_box(lo[0], lo[1], lo[2]));
			write_reg(REG_BOX_HI, pack_box(hi[0], hi[1], hi[2]));
		end
		write_reg(REG_ZOOM, ($urandom_range(0, 2) == 0) ? 24'($urandom()) :
			24'($urandom_range(4096, 262144)));
		write_reg(REG_CX, 17'($urandom()));
		write_reg(REG_CY, 17'($urandom()));
		write_reg(REG_SCALE, ($urandom_range(0, 2) == 0) ? 17'($urandom()) :
			17'($urandom_range(16, 16000)));
	endtask

	task automatic test_random_phases;
		logic signed [20:0] c[3];
		for (int ph = 0; ph < 10; ph++) begin
			random_config();
			repeat (120) begin
				for (int i = 0; i < 3; i++) begin
					if ($urandom_range(0, 3) == 0)
						c[i] = 21'($urandom());
					else
						c[i] = $signed(box_lo[i*21 +: 21]) +
							21'($urandom_range(0, 1 << $urandom_range(0, 20)));
				end
				send_point(c[0], c[1], c[2]);
			end
			drain();
		end
	endtask

	initial begin
		cam_wx = 64'h2000_0000_0000_0000;
		cam_yz = '0;
		box_lo = '0;
		box_hi = '0;
		zoom = 24'h010000;
		centre_x = '0;
		centre_y = '0;
		px_scale = 17'd16;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_rotation_and_box();
		test_zero_quat_inverted_box();
		test_zero_scale_and_saturation();
		test_random_phases();
		$display("Projected %0d points and checked %0d results over %0d configuration phases.",
			points_sent, results_seen, phases);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
